### design/fjs_pkg.sv
// shared types, constants and the control store for the job server sequencer
// depends on nothing; imported by fifo_job_server_with_timeouts
package fjs_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 3;
   localparam int ID_W   = 16;
   localparam int TIME_W = 24;
   localparam int LEN_W  = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_CHECK_LATE,
      ST_LOOP,
      ST_DROP,
      ST_SERVE,
      ST_FLUSH,
      ST_AFTER,
      ST_ADMIT,
      ST_DIRECT,
      ST_END
   } step_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_START,
      C_CMD,
      C_LATE,
      C_LOOP_DONE,
      C_DROP,
      C_EMPTY
   } cond_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_DROP,
      OP_SERVE,
      OP_ADMIT,
      OP_DIRECT,
      OP_FINISH
   } op_type;

   typedef struct packed {
      cond_type cond;
      step_type next_true;
      step_type next_false;
      op_type   op_true;
      op_type   op_false;
   } ucode_word_type;

   function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] x,
                                                 input logic [TIME_W-1:0] y);
      return (x > y) ? (x - y) : '0;
   endfunction

   // control store: condition, two jump targets and the datapath op for each branch
   function automatic ucode_word_type ucode_rom(input step_type s);
      ucode_word_type w;
      case (s)
         ST_IDLE:       w = '{C_START,     ST_CLASSIFY, ST_IDLE,       OP_NONE,   OP_NONE};
         ST_CLASSIFY:   w = '{C_CMD,       ST_FLUSH,    ST_CHECK_LATE, OP_NONE,   OP_NONE};
         ST_CHECK_LATE: w = '{C_LATE,      ST_ADMIT,    ST_LOOP,       OP_NONE,   OP_NONE};
         ST_LOOP:       w = '{C_LOOP_DONE, ST_AFTER,    ST_DROP,       OP_NONE,   OP_NONE};
         ST_DROP:       w = '{C_DROP,      ST_DROP,     ST_SERVE,      OP_DROP,   OP_NONE};
         ST_SERVE:      w = '{C_CMD,       ST_FLUSH,    ST_LOOP,       OP_SERVE,  OP_SERVE};
         ST_FLUSH:      w = '{C_EMPTY,     ST_END,      ST_DROP,       OP_NONE,   OP_NONE};
         ST_AFTER:      w = '{C_LATE,      ST_ADMIT,    ST_DIRECT,     OP_NONE,   OP_NONE};
         ST_ADMIT:      w = '{C_ALWAYS,    ST_END,      ST_END,        OP_ADMIT,  OP_ADMIT};
         ST_DIRECT:     w = '{C_ALWAYS,    ST_END,      ST_END,        OP_DIRECT, OP_DIRECT};
         ST_END:        w = '{C_ALWAYS,    ST_IDLE,     ST_IDLE,       OP_FINISH, OP_FINISH};
         default:       w = '{C_ALWAYS,    ST_IDLE,     ST_IDLE,       OP_NONE,   OP_NONE};
      endcase
      return w;
   endfunction

endpackage

### design/fifo_job_server_with_timeouts.sv
// single-server job queue with deadlines, driven by a microcoded step sequencer
// depends on fjs_pkg (types, control store, saturating subtract)
//
// usage:
//   - a request beat (job or flush) is taken when start is high and busy is low;
//     req_command 0 brings a job, 1 drains the queue (other fields ignored)
//   - each result is one beat on rsp_* marked by rsp_valid for one cycle;
//     rsp_last flags the final result of a request, a request may give none
//   - timing: the sequencer walks the control store one step per cycle; a job
//     with no queue work runs classify, check-late, loop, after, direct, end;
//     a serve loop pass runs loop, drop, serve, plus a drop per expired job
//   - a job arriving before the server clock that just joins the queue runs
//     classify, check-late, admit, end; no result. Empty flush: classify, flush, end
//   - a result leaves in the cycle after the next result of the same request is
//     known; the last in the cycle after the end step, when busy is already low
//   - reset clears the server clock, the queue count and the sequencer;
//     queue slots keep whatever they held and are only read once written
//   - the receiver cannot stall, so results never wait on the output side
module fifo_job_server_with_timeouts
   import fjs_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_command,
   input  logic [ID_W-1:0]   req_job_id,
   input  logic [TIME_W-1:0] req_arrive_time,
   input  logic [LEN_W-1:0]  req_run_length,
   input  logic [TIME_W-1:0] req_deadline,
   output logic              rsp_valid,
   output logic [ID_W-1:0]   rsp_done_id,
   output logic              rsp_aborted,
   output logic [TIME_W-1:0] rsp_event_time,
   output logic [TIME_W-1:0] rsp_wait_delay,
   output logic              rsp_last
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int PAD_W = TIME_W + 1 - LEN_W;

   // sequencer
   step_type       step_ff, step_in;
   ucode_word_type uword;
   logic           cond_hit;
   op_type         op;

   // latched request
   logic              cmd_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] arr_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [TIME_W-1:0] dl_ff;

   // server state and queue
   logic [TIME_W-1:0] clk_ff, clk_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ID_W-1:0]   q_id_ff  [QUEUE_DEPTH];
   logic [TIME_W-1:0] q_arr_ff [QUEUE_DEPTH];
   logic [LEN_W-1:0]  q_len_ff [QUEUE_DEPTH];
   logic [TIME_W-1:0] q_dl_ff  [QUEUE_DEPTH];

   // one result held back until we know whether it is the last
   logic              hold_valid_ff, hold_valid_in;
   logic [ID_W-1:0]   hold_id_ff;
   logic              hold_ab_ff;
   logic [TIME_W-1:0] hold_time_ff;
   logic [TIME_W-1:0] hold_delay_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_in;
   logic [ID_W-1:0]   rsp_id_ff;
   logic              rsp_ab_ff;
   logic [TIME_W-1:0] rsp_time_ff;
   logic [TIME_W-1:0] rsp_delay_ff;
   logic              rsp_last_ff;

   // datapath
   logic              empty, full, late, head_expired;
   logic [TIME_W:0]   head_sum, new_sum;
   logic              head_fits, new_fits;
   logic              emit, push, pop;
   logic [ID_W-1:0]   e_id;
   logic              e_ab;
   logic [TIME_W-1:0] e_time, e_delay;

   assign empty        = (count_ff == '0);
   assign full         = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign late         = (arr_ff < clk_ff);
   assign head_expired = (q_dl_ff[0] <= clk_ff);
   assign head_sum     = {1'b0, clk_ff} + {{PAD_W{1'b0}}, q_len_ff[0]};
   assign new_sum      = {1'b0, arr_ff} + {{PAD_W{1'b0}}, len_ff};
   assign head_fits    = (head_sum <= {1'b0, q_dl_ff[0]});
   assign new_fits     = (new_sum <= {1'b0, dl_ff});

   // control store fetch and branch
   always_comb begin
      uword = ucode_rom(step_ff);
      case (uword.cond)
         C_ALWAYS:    cond_hit = 1'b1;
         C_START:     cond_hit = start;
         C_CMD:       cond_hit = cmd_ff;
         C_LATE:      cond_hit = late;
         C_LOOP_DONE: cond_hit = empty || late;
         C_DROP:      cond_hit = !empty && head_expired;
         C_EMPTY:     cond_hit = empty;
         default:     cond_hit = 1'b0;
      endcase
      step_in = cond_hit ? uword.next_true : uword.next_false;
      op      = cond_hit ? uword.op_true : uword.op_false;
   end

   always_comb begin
      emit    = 1'b0;
      push    = 1'b0;
      pop     = 1'b0;
      clk_in  = clk_ff;
      e_id    = id_ff;
      e_ab    = 1'b1;
      e_time  = clk_ff;
      e_delay = '0;
      case (op)
         OP_DROP: begin
            emit    = 1'b1;
            pop     = 1'b1;
            e_id    = q_id_ff[0];
            e_time  = clk_ff;
            e_delay = sat_sub(clk_ff, q_arr_ff[0]);
         end
         OP_SERVE: begin
            if (!empty) begin
               emit = 1'b1;
               pop  = 1'b1;
               e_id = q_id_ff[0];
               if (head_fits) begin
                  e_ab    = 1'b0;
                  e_time  = head_sum[TIME_W-1:0];
                  e_delay = sat_sub(clk_ff, q_arr_ff[0]);
                  clk_in  = head_sum[TIME_W-1:0];
               end else begin
                  e_time  = q_dl_ff[0];
                  e_delay = sat_sub(q_dl_ff[0], q_arr_ff[0]);
                  clk_in  = q_dl_ff[0];
               end
            end
         end
         OP_ADMIT: begin
            if (full) begin
               emit   = 1'b1;
               e_time = arr_ff;
            end else begin
               push = 1'b1;
            end
         end
         OP_DIRECT: begin
            emit = 1'b1;
            if (new_fits) begin
               e_ab   = 1'b0;
               e_time = new_sum[TIME_W-1:0];
               clk_in = new_sum[TIME_W-1:0];
            end else begin
               e_time  = dl_ff;
               e_delay = sat_sub(dl_ff, arr_ff);
               clk_in  = dl_ff;
            end
         end
         default: begin
         end
      endcase

      count_in = count_ff;
      if (push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop) begin
         count_in = count_ff - CNT_W'(1);
      end

      // a new result pushes out the held one; the end step releases it as last
      rsp_valid_in  = hold_valid_ff && (emit || (op == OP_FINISH));
      rsp_last_in   = (op == OP_FINISH);
      hold_valid_in = emit ? 1'b1 : ((op == OP_FINISH) ? 1'b0 : hold_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= ST_IDLE;
         clk_ff        <= '0;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         clk_ff        <= clk_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && (step_ff == ST_IDLE)) begin
         cmd_ff <= req_command;
         id_ff  <= req_job_id;
         arr_ff <= req_arrive_time;
         len_ff <= req_run_length;
         dl_ff  <= req_deadline;
      end
      if (emit) begin
         hold_id_ff    <= e_id;
         hold_ab_ff    <= e_ab;
         hold_time_ff  <= e_time;
         hold_delay_ff <= e_delay;
      end
      if (rsp_valid_in) begin
         rsp_id_ff    <= hold_id_ff;
         rsp_ab_ff    <= hold_ab_ff;
         rsp_time_ff  <= hold_time_ff;
         rsp_delay_ff <= hold_delay_ff;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // queue slots: shift toward the head on pop, write at the tail on push
   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_id_ff[i]  <= q_id_ff[i+1];
            q_arr_ff[i] <= q_arr_ff[i+1];
            q_len_ff[i] <= q_len_ff[i+1];
            q_dl_ff[i]  <= q_dl_ff[i+1];
         end
      end else if (push) begin
         q_id_ff[count_ff[IDX_W-1:0]]  <= id_ff;
         q_arr_ff[count_ff[IDX_W-1:0]] <= arr_ff;
         q_len_ff[count_ff[IDX_W-1:0]] <= len_ff;
         q_dl_ff[count_ff[IDX_W-1:0]]  <= dl_ff;
      end
   end

   assign busy           = (step_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_done_id    = rsp_id_ff;
   assign rsp_aborted    = rsp_ab_ff;
   assign rsp_event_time = rsp_time_ff;
   assign rsp_wait_delay = rsp_delay_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_last_from_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> ($past(step_ff) == ST_END))
      else $error("last beat not released by the end step");

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("result still held while idle");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (step_ff == ST_CLASSIFY))
      else $error("accepted request did not start the program");
`endif

endmodule
